// ----- hw/rtl/vpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants for the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

    // default geometry
    localparam int NUM_PARTS_DEF = 16;
    localparam int SIZE_BITS_DEF = 16;

    // field widths of the stream beats
    localparam int IDX_FLD_W  = 4;
    localparam int SIZE_FLD_W = 16;
    localparam int S_TDATA_W  = 40;  // 37 bits of fields, padded to 5 bytes
    localparam int M_TDATA_W  = 24;  // 21 bits of fields, padded to 3 bytes

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int MODE_W     = 2;
    localparam int PIU_W      = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTS_IN_USE = 1'd1;

    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    localparam logic [MODE_W-1:0] FIT_MODE_RST = FIT_FIRST;
    localparam logic [PIU_W-1:0]  PIU_RST      = 5'd16;

    // input kind carried on tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_UPDATE,
        S_RESULT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;      // latch the input beat, clear search state
        logic load_write;  // write the latched entry into the table
        logic scan_step;   // read the entry under the scan counter, advance
        logic upd_write;   // write back the chosen entry
        logic out_load;    // move the result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_empty;  // search bound is zero
        logic scan_last;   // scan counter at the last entry to search
        logic out_busy;    // output register holds a beat not taken this cycle
    } t_status;

endpackage

// ----- hw/rtl/vpa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module vpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/vpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer: takes one beat, runs the load or the table scan, issues result.
// ----------------------------------------------------------------------------
module vpa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_func,
    output logic             o_ready,
    input  vpa_pkg::t_status i_sts,
    output vpa_pkg::t_cmd    o_cmd
);

    import vpa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_func == FUNC_LOAD) begin
                        n_state = S_LOAD;
                    end else if (i_sts.scan_empty) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_LOAD:   n_state = S_RESULT;
            S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_UPDATE;
            S_UPDATE: n_state = S_RESULT;
            S_RESULT: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            S_LOAD:   o_cmd.load_write = 1'b1;
            S_SCAN:   o_cmd.scan_step  = 1'b1;
            S_DRAIN:  o_cmd            = '0;
            S_UPDATE: o_cmd.upd_write  = 1'b1;
            S_RESULT: o_cmd.out_load   = !i_sts.out_busy;
            default:  o_cmd            = '0;
        endcase
    end

endmodule

// ----- hw/rtl/vpa_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_dpath
// Partition table, config registers, scan compare and result register.
// ----------------------------------------------------------------------------
module vpa_dpath #(
    parameter int NUM_PARTS = vpa_pkg::NUM_PARTS_DEF,
    parameter int SIZE_BITS = vpa_pkg::SIZE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vpa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [vpa_pkg::S_TDATA_W-1:0]  i_tdata,
    input  vpa_pkg::t_cmd                  i_cmd,
    output vpa_pkg::t_status               o_sts,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [vpa_pkg::M_TDATA_W-1:0]  o_m_tdata
);

    import vpa_pkg::*;

    localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
    localparam int CNT_W = $clog2(NUM_PARTS + 1);

    // config
    logic [MODE_W-1:0] r_fit_mode;
    logic [PIU_W-1:0]  r_piu;
    logic [CNT_W-1:0]  w_limit;

    // latched beat
    logic [IDX_FLD_W-1:0] r_idx;
    logic [SIZE_BITS-1:0] r_size;
    logic                 r_fill;
    logic [SIZE_BITS-1:0] r_req;

    // scan
    logic [IDX_W-1:0]     r_cnt;
    logic                 r_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_pick;
    logic [SIZE_BITS-1:0] r_best;
    logic [NUM_PARTS-1:0] r_occ;

    logic                 w_in_range;
    logic [IDX_W-1:0]     w_load_addr;
    logic [SIZE_BITS-1:0] w_rdata;
    logic [SIZE_BITS-1:0] w_rem;
    logic                 w_elig;
    logic                 w_take;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [SIZE_BITS-1:0] w_wdata;

    // result register
    logic                 r_out_vld;
    logic [M_TDATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= FIT_MODE_RST;
            r_piu      <= PIU_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIT_MODE:     r_fit_mode <= i_cfg_data[MODE_W-1:0];
                CFG_PARTS_IN_USE: r_piu      <= i_cfg_data[PIU_W-1:0];
                default:          r_piu      <= r_piu;
            endcase
        end
    end

    // search bound saturates at the table depth
    assign w_limit = (32'(r_piu) > NUM_PARTS) ? CNT_W'(NUM_PARTS) : CNT_W'(r_piu);

    assign w_in_range  = 32'(r_idx) < NUM_PARTS;
    assign w_load_addr = IDX_W'(r_idx);
    assign w_rem       = r_best - r_req;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx  <= i_tdata[3:0];
            r_size <= SIZE_BITS'(i_tdata[19:4]);
            r_fill <= i_tdata[20];
            r_req  <= SIZE_BITS'(i_tdata[36:21]);
        end
    end

    // read data of entry r_cmp_idx arrives in the cycle after its address
    assign w_elig = r_cmp_vld && !r_occ[r_cmp_idx] && (w_rdata >= r_req);

    always_comb begin
        w_take = 1'b0;
        if (w_elig) begin
            if (!r_found) begin
                w_take = 1'b1;
            end else begin
                case (r_fit_mode)
                    FIT_BEST:  w_take = w_rdata < r_best;
                    FIT_WORST: w_take = w_rdata > r_best;
                    default:   w_take = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_cmp_vld <= i_cmd.scan_step;
            if (i_cmd.accept) begin
                r_found <= 1'b0;
                r_cnt   <= '0;
            end else begin
                if (w_take) begin
                    r_found <= 1'b1;
                end
                if (i_cmd.scan_step) begin
                    r_cnt <= r_cnt + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_cnt;
        if (w_take) begin
            r_pick <= r_cmp_idx;
            r_best <= w_rdata;
        end else if (i_cmd.upd_write && r_found) begin
            r_best <= w_rem;
        end
    end

    // occupied flags, all set at reset so nothing is eligible until loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '1;
        end else if (i_cmd.load_write && w_in_range) begin
            r_occ[w_load_addr] <= r_fill;
        end
    end

    always_comb begin
        if (i_cmd.load_write) begin
            w_we    = w_in_range;
            w_waddr = w_load_addr;
            w_wdata = r_size;
        end else begin
            w_we    = i_cmd.upd_write && r_found;
            w_waddr = r_pick;
            w_wdata = w_rem;
        end
    end

    vpa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_PARTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cnt),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_found) begin
                r_out_data <= M_TDATA_W'({SIZE_FLD_W'(r_best), IDX_FLD_W'(r_pick), 1'b1});
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_sts.scan_empty = (w_limit == '0);
    assign o_sts.scan_last  = (CNT_W'(r_cnt) + CNT_W'(1)) == w_limit;
    assign o_sts.out_busy   = r_out_vld && !i_m_tready;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule

// ----- hw/rtl/variable_partition_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator
// Partition table with first, best or worst fit allocation.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata 40b, tuser 1b (func)
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata 24b
//  cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
//  One beat in flight at a time. A load writes the table entry, then issues the
//  result. An allocate does one RAM read per searched partition, pipelined
//  against the registered read, then a drain and a write-back. Reset is
//  synchronous, active low; it sets all partitions occupied. A stalled result
//  holds the sequencer in its result state, the next beat is accepted as soon
//  as the result is registered.
// ----------------------------------------------------------------------------
module variable_partition_allocator #(
    parameter int NUM_PARTS = vpa_pkg::NUM_PARTS_DEF,
    parameter int SIZE_BITS = vpa_pkg::SIZE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vpa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // part_index[3:0], part_size[19:4], part_filled[20], request_size[36:21]
    input  logic [vpa_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // func[0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // granted[0], granted_index[4:1], remaining_size[20:5]
    output logic [vpa_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    import vpa_pkg::*;

    t_cmd    w_cmd;
    t_status w_sts;

    vpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_func  (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    vpa_dpath #(
        .NUM_PARTS (NUM_PARTS),
        .SIZE_BITS (SIZE_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tdata    (s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

// ----- hw/rtl/vpa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_checker
// Port-level checks for the variable partition allocator.
// ----------------------------------------------------------------------------
module vpa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [vpa_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic       w_in_beat;
    logic       w_out_beat;
    logic [1:0] r_pend;

    assign w_in_beat  = s_axis_tvalid && s_axis_tready;
    assign w_out_beat = m_axis_tvalid && m_axis_tready;

    // beats accepted and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else if (w_in_beat && !w_out_beat) begin
            r_pend <= r_pend + 2'd1;
        end else if (w_out_beat && !w_in_beat) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat |-> r_pend != 2'd0)
        else $error("result beat without an accepted input beat");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("too many input beats outstanding");

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !s_axis_tready)
        else $error("second beat accepted while one is in work");

    a_refusal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[20:1] == 20'd0)
        else $error("refusal carries nonzero index or size");

endmodule

bind variable_partition_allocator vpa_checker u_vpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/vpa_alloc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_alloc_checker
// Watches the config port and both streams of the partition allocator. It
// keeps its own partition table, predicts the grant for every accepted input
// beat and compares each output beat against the oldest prediction.
// ----------------------------------------------------------------------------
module vpa_alloc_checker
    import vpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_valid,
    input  logic                  i_s_ready,
    input  logic [S_TDATA_W-1:0]  i_s_data,
    input  logic                  i_s_user,
    input  logic                  i_m_valid,
    input  logic                  i_m_ready,
    input  logic [M_TDATA_W-1:0]  i_m_data,
    output int                    o_errors,
    output int                    o_owed
);

    // last member sits in the low bits, matching the tdata layout
    typedef struct packed {
        logic [SIZE_FLD_W-1:0] remain;
        logic [IDX_FLD_W-1:0]  index;
        logic                  granted;
    } t_grant;

    logic [SIZE_FLD_W-1:0] free_size [NUM_PARTS_DEF];
    logic                  occupied  [NUM_PARTS_DEF];
    logic [MODE_W-1:0]     fit_mode;
    logic [PIU_W-1:0]      parts_in_use;
    t_grant                grant_q [$];
    int                    n_err = 0;
    int                    owed  = 0;

    assign o_errors = n_err;
    assign o_owed   = owed;

    // Updates the table for one input beat and returns the grant it causes.
    function automatic t_grant place_request(logic func, logic [S_TDATA_W-1:0] d);
        t_grant                g;
        logic [IDX_FLD_W-1:0]  ld_idx;
        logic [SIZE_FLD_W-1:0] req;
        int                    limit;
        int                    pick;
        bit                    found;
        g      = '0;
        ld_idx = d[3:0];
        req    = d[36:21];
        pick   = 0;
        found  = 1'b0;
        if (func == FUNC_LOAD) begin
            free_size[ld_idx] = d[19:4];
            occupied[ld_idx]  = d[20];
            return g;
        end
        limit = (parts_in_use > NUM_PARTS_DEF) ? NUM_PARTS_DEF : int'(parts_in_use);
        for (int i = 0; i < limit; i++) begin
            if (!occupied[i] && free_size[i] >= req) begin
                if (!found) begin
                    found = 1'b1;
                    pick  = i;
                    if (fit_mode != FIT_BEST && fit_mode != FIT_WORST)
                        break;
                end else if (fit_mode == FIT_BEST && free_size[i] < free_size[pick]) begin
                    pick = i;
                end else if (fit_mode == FIT_WORST && free_size[i] > free_size[pick]) begin
                    pick = i;
                end
            end
        end
        if (found) begin
            free_size[pick] = free_size[pick] - req;
            g.granted = 1'b1;
            g.index   = pick[IDX_FLD_W-1:0];
            g.remain  = free_size[pick];
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        t_grant got;
        if (!i_rst_n) begin
            fit_mode     = FIT_MODE_RST;
            parts_in_use = PIU_RST;
            for (int i = 0; i < NUM_PARTS_DEF; i++) begin
                free_size[i] = '0;
                occupied[i]  = 1'b1;
            end
            grant_q.delete();
            owed = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FIT_MODE)
                    fit_mode = i_cfg_data[MODE_W-1:0];
                else if (i_cfg_idx == CFG_PARTS_IN_USE)
                    parts_in_use = i_cfg_data[PIU_W-1:0];
            end
            // output first: a beat taken at this edge belongs to an older input
            if (i_m_valid && i_m_ready) begin
                got = t_grant'(i_m_data[20:0]);
                if (grant_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("%0t: unexpected result beat %h", $realtime, i_m_data);
                end else begin
                    want = grant_q.pop_front();
                    if (got.granted != want.granted || got.index != want.index ||
                            got.remain != want.remain) begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"%0t: mismatch granted %0d/%0d index %0d/%0d",
                                      " remain %0d/%0d (exp/act)"},
                                $realtime, want.granted, got.granted, want.index, got.index,
                                want.remain, got.remain);
                    end
                end
            end
            if (i_s_valid && i_s_ready)
                grant_q.push_back(place_request(i_s_user, i_s_data));
            owed = grant_q.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the partition allocator: a directed pass over the fit modes,
// search bounds and corner sizes, then random table loads and requests under
// changing settings and back-pressure. Checking is done in vpa_alloc_checker.
// ----------------------------------------------------------------------------
module tb;
    import vpa_pkg::*;

    localparam int               QUIET_LIMIT = 2000;
    localparam logic [MODE_W-1:0] FIT_SPARE  = 2'd3;  // unused code, acts as first fit

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    int errors;
    int owed;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles  = 0;

    variable_partition_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    vpa_alloc_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_valid  (s_axis_tvalid),
        .i_s_ready  (s_axis_tready),
        .i_s_data   (s_axis_tdata),
        .i_s_user   (s_axis_tuser),
        .i_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .i_m_data   (m_axis_tdata),
        .o_errors   (errors),
        .o_owed     (owed)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic [SIZE_FLD_W-1:0] rand_part_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return SIZE_FLD_W'($urandom_range(0, 65535));
            default: return SIZE_FLD_W'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic logic [SIZE_FLD_W-1:0] rand_request();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return SIZE_FLD_W'($urandom_range(0, 65535));
            default: return SIZE_FLD_W'($urandom_range(0, 600));
        endcase
    endfunction

    // Called and returns at a falling edge; tvalid is low on return.
    task automatic push_beat(input logic func, input logic [3:0] idx,
                             input logic [SIZE_FLD_W-1:0] size, input logic fill,
                             input logic [SIZE_FLD_W-1:0] req);
        while ($urandom_range(0, 99) < send_idle_pct)
            @(negedge i_clk);
        s_axis_tdata  = {3'b000, req, fill, size, idx};
        s_axis_tuser  = func;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Unused fields of each kind carry random noise.
    task automatic load_part(input logic [3:0] idx, input logic [SIZE_FLD_W-1:0] size,
                             input logic fill);
        push_beat(FUNC_LOAD, idx, size, fill, SIZE_FLD_W'($urandom));
    endtask

    task automatic request_alloc(input logic [SIZE_FLD_W-1:0] req);
        push_beat(FUNC_ALLOC, 4'($urandom), SIZE_FLD_W'($urandom), 1'($urandom), req);
    endtask

    task automatic drain();
        while (owed != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Only while idle: waits for every result before writing.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] piu;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed part
        request_alloc(16'd0);                    // all partitions occupied after reset
        load_part(4'd0, 16'd0, 1'b0);
        request_alloc(16'd0);                    // zero request into an empty partition
        load_part(4'd15, 16'hFFFF, 1'b0);
        load_part(4'd5, 16'd100, 1'b0);
        load_part(4'd3, 16'd500, 1'b1);          // occupied, never picked
        load_part(4'd7, 16'd300, 1'b0);
        request_alloc(16'hFFFF);
        request_alloc(16'hFFFF);                 // nothing large enough
        write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_BEST));
        request_alloc(16'd50);
        load_part(4'd2, 16'd50, 1'b0);           // tie with partition 5
        request_alloc(16'd20);
        write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_WORST));
        request_alloc(16'd10);
        load_part(4'd9, 16'd290, 1'b0);          // tie on the largest size
        request_alloc(16'd1);
        write_reg(CFG_FIT_MODE, CFG_DATA_W'(FIT_SPARE));
        request_alloc(16'd10);
        write_reg(CFG_PARTS_IN_USE, 5'd1);
        request_alloc(16'd0);
        request_alloc(16'd1);
        write_reg(CFG_PARTS_IN_USE, 5'd0);       // empty search
        request_alloc(16'd0);
        write_reg(CFG_PARTS_IN_USE, 5'd31);      // saturates at the table size
        request_alloc(16'd5);
        load_part(4'd15, 16'hFFFF, 1'b1);

        // random part
        for (int ph = 0; ph < 12; ph++) begin
            if (ph < 4) begin
                send_idle_pct = 23;
                recv_idle_pct = 47;
            end else if (ph < 8) begin
                send_idle_pct = 47;
                recv_idle_pct = 23;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(CFG_FIT_MODE, CFG_DATA_W'($urandom_range(0, 3)));
            case ($urandom_range(0, 9))
                0:       piu = 5'd0;
                1:       piu = 5'd1;
                2:       piu = CFG_DATA_W'($urandom_range(17, 31));
                3, 4:    piu = 5'd16;
                default: piu = CFG_DATA_W'($urandom_range(2, 16));
            endcase
            write_reg(CFG_PARTS_IN_USE, piu);
            // fill most of the table, then work on it
            for (int p = 0; p < NUM_PARTS_DEF; p++)
                if ($urandom_range(0, 3) != 0)
                    load_part(p[3:0], rand_part_size(), $urandom_range(0, 4) == 0);
            for (int n = 0; n < 45; n++) begin
                if ($urandom_range(0, 9) < 7)
                    request_alloc(rand_request());
                else
                    load_part(4'($urandom), rand_part_size(), $urandom_range(0, 4) == 0);
                if ($urandom_range(0, 39) == 0)
                    drain();
            end
        end

        drain();
        repeat (30) @(negedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
